// ===== sv/okvt_pkg.sv =====
// ----------------------------------------------------------------------------
// okvt_pkg: shared types and constants of the ordered key/value table
// Operation and status codes, and the value that a failed lookup returns.
// ----------------------------------------------------------------------------
package okvt_pkg;

    // Operation carried by a request beat.
    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_SET    = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_GET    = 2'd3
    } t_func;

    // Completion status carried by a response beat.
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef logic signed [31:0] t_word;

    localparam int unsigned OCC_W = 5;

    // Value returned by a get that finds no entry.
    localparam t_word NOT_FOUND_VALUE = -32'sd1;

endpackage

// ===== sv/okvt_if.sv =====
// ----------------------------------------------------------------------------
// okvt_if: request and response channels of the ordered key/value table
// Valid/ready channels; a beat moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface okvt_req_if
    import okvt_pkg::*;
();
    logic  valid;
    logic  ready;
    t_func func;
    t_word key;
    t_word value;

    modport source (output valid, output func, output key, output value, input ready);
    modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface okvt_rsp_if
    import okvt_pkg::*;
();
    logic             valid;
    logic             ready;
    t_word            read_value;
    t_status          status;
    logic [OCC_W-1:0] occupancy;

    modport source (output valid, output read_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input read_value, input status, input occupancy,
                    output ready);
endinterface

// ===== sv/okvt_ram.sv =====
// ----------------------------------------------------------------------------
// okvt_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module okvt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/ordered_key_value_table.sv =====
// ----------------------------------------------------------------------------
// ordered_key_value_table: bounded, insertion-ordered key/value table
// Signed 32-bit pairs kept in one RAM in the order they were stored.
// ----------------------------------------------------------------------------
// The table holds up to TABLE_DEPTH key/value pairs in one RAM, oldest first,
// and serves one request at a time. Add appends a pair, even when the key is
// already present. Set updates the first entry with the key, or appends when
// no entry matches. Delete removes the first matching entry and moves every
// later entry down one place. Get returns the first match's value, or -1 with
// not-found status. Appending to a full table stores nothing and reports full.
// Timing is set by the single RAM read port, which the search and the
// compaction both walk one entry per cycle. A delete that matches then
// moves the later entries down and drops the count. The response sits in
// an output register, so a request may be accepted while the previous
// response still waits to be taken. No clearing pass is needed after
// reset: only entries below the count are ever read.
module ordered_key_value_table
    import okvt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    okvt_req_if.sink   i_req,
    okvt_rsp_if.source o_rsp
);
    // Entry address width and count width (the count may equal the depth).
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_APPEND,
        S_DONE
    } t_state;

    t_state r_state;

    // Latched request.
    t_func r_func;
    t_word r_key;
    t_word r_value;

    // Number of stored entries.
    logic [CW-1:0] r_count;

    // Read pointer, and the entry whose data arrives from the RAM this cycle.
    logic [CW-1:0] r_rd_idx;
    logic          r_pend;
    logic [AW-1:0] r_pend_idx;

    // Result under construction, and the output register.
    t_word            r_res_value;
    t_status          r_res_status;
    logic             r_out_valid;
    t_word            r_out_value;
    t_status          r_out_status;
    logic [OCC_W-1:0] r_out_occ;

    // RAM port signals. Each word is the key in the upper half, value below.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [63:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [63:0]   ram_rdata;

    logic        w_found;
    logic        w_more;
    logic        w_room;
    logic        w_out_load;
    logic [31:0] w_count_ext;

    okvt_ram #(
        .WIDTH (64),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The entry read last cycle matches the key being searched for.
    assign w_found = r_pend && (ram_rdata[63:32] == r_key);
    // Entries remain to be read in the walk.
    assign w_more  = r_rd_idx < r_count;
    // There is space for one more entry.
    assign w_room  = r_count < CW'(TABLE_DEPTH);
    // The finished result moves into the output register this cycle.
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    // The occupancy field reports the count modulo 32.
    assign w_count_ext = 32'(r_count);

    assign ram_raddr = r_rd_idx[AW-1:0];

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_count[AW-1:0];
        ram_wdata = {r_key, r_value};
        case (r_state)
            S_SCAN: begin
                // A set that hits rewrites the matching entry in place.
                if (w_found && r_func == FUNC_SET) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pend_idx;
                end
            end
            S_SHIFT: begin
                // Each entry read during compaction moves down one place.
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pend_idx - AW'(1);
                    ram_wdata = ram_rdata;
                end
            end
            S_APPEND: begin
                ram_we = w_room;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_rsp.ready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_func       <= i_req.func;
                        r_key        <= i_req.key;
                        r_value      <= i_req.value;
                        r_rd_idx     <= '0;
                        r_pend       <= 1'b0;
                        r_res_value  <= '0;
                        r_res_status <= ST_DONE;
                        r_state      <= (i_req.func == FUNC_ADD) ? S_APPEND : S_SCAN;
                    end
                end

                S_SCAN: begin
                    if (w_found) begin
                        r_pend <= 1'b0;
                        case (r_func)
                            FUNC_GET: begin
                                r_res_value <= ram_rdata[31:0];
                                r_state     <= S_DONE;
                            end
                            FUNC_DELETE: begin
                                // The read pointer already sits just past the hit.
                                r_state <= S_SHIFT;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end else if (w_more) begin
                        r_pend     <= 1'b1;
                        r_pend_idx <= r_rd_idx[AW-1:0];
                        r_rd_idx   <= r_rd_idx + CW'(1);
                    end else begin
                        r_pend <= 1'b0;
                        case (r_func)
                            FUNC_SET: begin
                                r_state <= S_APPEND;
                            end
                            FUNC_GET: begin
                                r_res_value  <= NOT_FOUND_VALUE;
                                r_res_status <= ST_NOT_FOUND;
                                r_state      <= S_DONE;
                            end
                            default: begin
                                r_res_status <= ST_NOT_FOUND;
                                r_state      <= S_DONE;
                            end
                        endcase
                    end
                end

                S_SHIFT: begin
                    if (w_more) begin
                        r_pend     <= 1'b1;
                        r_pend_idx <= r_rd_idx[AW-1:0];
                        r_rd_idx   <= r_rd_idx + CW'(1);
                    end else begin
                        r_pend <= 1'b0;
                        // Once the last move has been written, drop the count.
                        if (!r_pend) begin
                            r_count <= r_count - CW'(1);
                            r_state <= S_DONE;
                        end
                    end
                end

                S_APPEND: begin
                    if (w_room) begin
                        r_count <= r_count + CW'(1);
                    end else begin
                        r_res_status <= ST_FULL;
                    end
                    r_state <= S_DONE;
                end

                S_DONE: begin
                    if (w_out_load) begin
                        r_out_valid  <= 1'b1;
                        r_out_value  <= r_res_value;
                        r_out_status <= r_res_status;
                        r_out_occ    <= w_count_ext[OCC_W-1:0];
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_value = r_out_value;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.occupancy  = r_out_occ;

    // The count never passes the table depth.
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    // An accepted request always leaves the idle state.
    a_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // The RAM is written only while an operation is in progress.
    a_write_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_SCAN || r_state == S_SHIFT || r_state == S_APPEND))
        else $error("RAM write outside an operation");

    // Compaction only runs on a table that holds the entry being removed.
    a_shift_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_count != '0))
        else $error("compaction on an empty table");
endmodule

// ===== dv/okvt_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okvt_table_checker: response checker for the ordered key/value table
// Keeps its own copy of the table, predicts the response to every accepted
// request beat and compares each accepted response beat field by field.
// ----------------------------------------------------------------------------
module okvt_table_checker
    import okvt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    okvt_req_if  i_req,
    okvt_rsp_if  i_rsp,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked,
    output int   o_full_seen,
    output int   o_miss_seen
);

    typedef struct packed {
        t_word            read_value;
        t_status          status;
        logic [OCC_W-1:0] occupancy;
    } t_outcome;

    // Shadow copy of the table, oldest entry at index zero.
    t_word    shadow_keys   [TABLE_DEPTH];
    t_word    shadow_values [TABLE_DEPTH];
    int       shadow_count;
    t_outcome outcome_q [$];

    task automatic report_fault(input string msg);
        $display("%0t ns: %s", $time, msg);
        o_errors++;
    endtask

    function automatic t_outcome predict_request(input t_func func, input t_word key,
                                                 input t_word value);
        t_outcome res;
        int       hit;
        res.read_value = '0;
        res.status     = ST_DONE;
        hit            = -1;
        // The search covers every stored entry, the newest one included.
        for (int i = 0; i < shadow_count; i++) begin
            if (hit < 0 && shadow_keys[i] == key) hit = i;
        end
        case (func)
            FUNC_ADD, FUNC_SET: begin
                if (func == FUNC_SET && hit >= 0) begin
                    shadow_values[hit] = value;
                end else if (shadow_count < TABLE_DEPTH) begin
                    shadow_keys[shadow_count]   = key;
                    shadow_values[shadow_count] = value;
                    shadow_count++;
                end else begin
                    res.status = ST_FULL;
                end
            end
            FUNC_DELETE: begin
                if (hit >= 0) begin
                    for (int i = hit; i + 1 < shadow_count; i++) begin
                        shadow_keys[i]   = shadow_keys[i + 1];
                        shadow_values[i] = shadow_values[i + 1];
                    end
                    shadow_count--;
                end else begin
                    res.status = ST_NOT_FOUND;
                end
            end
            default: begin
                if (hit >= 0) begin
                    res.read_value = shadow_values[hit];
                end else begin
                    res.read_value = NOT_FOUND_VALUE;
                    res.status     = ST_NOT_FOUND;
                end
            end
        endcase
        res.occupancy = OCC_W'(shadow_count);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_outcome want;
        if (!i_rst_n) begin
            shadow_count = 0;
            outcome_q.delete();
        end else begin
            // A response beat always belongs to an earlier request, so it is
            // retired before a request beat of the same edge is queued.
            if (i_rsp.valid && i_rsp.ready) begin
                if (outcome_q.size() == 0) begin
                    report_fault($sformatf("unexpected response: value %h status %0d occ %0d",
                                           i_rsp.read_value, i_rsp.status, i_rsp.occupancy));
                end else begin
                    want = outcome_q.pop_front();
                    o_checked++;
                    if (i_rsp.read_value !== want.read_value)
                        report_fault($sformatf("read_value %h, expected %h",
                                               i_rsp.read_value, want.read_value));
                    if (i_rsp.status !== want.status)
                        report_fault($sformatf("status %0d, expected %0d",
                                               i_rsp.status, want.status));
                    if (i_rsp.occupancy !== want.occupancy)
                        report_fault($sformatf("occupancy %0d, expected %0d",
                                               i_rsp.occupancy, want.occupancy));
                    if (want.status == ST_FULL) o_full_seen++;
                    if (want.status == ST_NOT_FOUND) o_miss_seen++;
                end
            end
            if (i_req.valid && i_req.ready)
                outcome_q.push_back(predict_request(i_req.func, i_req.key, i_req.value));
        end
        o_pending = outcome_q.size();
    end

endmodule

// ===== dv/tb_ordered_key_value_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_key_value_table: regression bench for the ordered key/value table
// Drives request beats with random gaps and response back-pressure, while a
// checker beside the block predicts and compares every response beat.
// ----------------------------------------------------------------------------
module tb_ordered_key_value_table;
    import okvt_pkg::*;

    localparam int TABLE_DEPTH   = 16;
    localparam int RANDOM_ITEMS  = 1350;
    // A delete that matches the oldest entry of a full table is among the
    // slowest operations, so this covers any beat still in flight.
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_LIMIT   = 4000;

    localparam t_word KEY_MIN = 32'sh8000_0000;
    localparam t_word KEY_MAX = 32'sh7fff_ffff;

    // Operation mixes of the random phases.
    localparam int MIX_GROW   = 0;
    localparam int MIX_SHRINK = 1;
    localparam int MIX_CHURN  = 2;

    logic  i_clk;
    logic  i_rst_n;
    // While calm is high neither side idles, giving back-to-back stretches.
    logic  calm;
    int    errors;
    int    pending;
    int    checked;
    int    full_seen;
    int    miss_seen;
    int    items_sent;
    int    sent_by_op [4];
    // Keys of the current phase; drawing most keys from a small pool is what
    // makes set, get and delete hit stored entries instead of missing.
    t_word key_pool [8];

    okvt_req_if req_ch ();
    okvt_rsp_if rsp_ch ();

    ordered_key_value_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    okvt_table_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .i_rsp      (rsp_ch),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_checked  (checked),
        .o_full_seen(full_seen),
        .o_miss_seen(miss_seen)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Corner values show up often enough that every field sees its extremes.
    function automatic t_word corner_or_random();
        case ($urandom_range(0, 11))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_word pick_key();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return key_pool[$urandom_range(0, 7)];
    endfunction

    function automatic t_func pick_func(input int mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_GROW: begin
                if (r < 45) return FUNC_ADD;
                if (r < 70) return FUNC_SET;
                if (r < 80) return FUNC_DELETE;
                return FUNC_GET;
            end
            MIX_SHRINK: begin
                if (r < 10) return FUNC_ADD;
                if (r < 20) return FUNC_SET;
                if (r < 65) return FUNC_DELETE;
                return FUNC_GET;
            end
            default: begin
                if (r < 25) return FUNC_ADD;
                if (r < 50) return FUNC_SET;
                if (r < 75) return FUNC_DELETE;
                return FUNC_GET;
            end
        endcase
    endfunction

    // Called at a falling edge and returns at the falling edge after the beat
    // was accepted. Valid is only lowered when a gap follows, so a beat that
    // directly follows another keeps valid high without a glitch.
    task automatic send_request(input t_func func, input t_word key, input t_word value);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func  <= func;
        req_ch.key   <= key;
        req_ch.value <= value;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
        sent_by_op[int'(func)]++;
    endtask

    // Holds the request channel idle until every outstanding response beat
    // has been taken. The checker updates its count at rising edges, so it is
    // read at falling edges only.
    task automatic wait_for_all_responses();
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Walks the special cases on a freshly reset table: lookup and delete on
    // an empty table, a fill to the brim with duplicate and extreme keys,
    // appends refused on a full table, a set that still updates when full, a
    // set whose match is the newest entry, duplicate keys resolved to the
    // oldest entry, and a delete of the oldest entry that moves the rest down.
    task automatic run_directed();
        send_request(FUNC_GET, 32'sd0, 32'sd0);
        send_request(FUNC_DELETE, 32'sd0, KEY_MAX);
        send_request(FUNC_ADD, KEY_MIN, KEY_MAX);
        send_request(FUNC_ADD, KEY_MAX, KEY_MIN);
        send_request(FUNC_ADD, -32'sd1, -32'sd1);
        send_request(FUNC_ADD, -32'sd1, 32'sd7);
        for (int i = 4; i < TABLE_DEPTH; i++) begin
            send_request(FUNC_ADD, t_word'(i * 3), ~t_word'(i));
        end
        send_request(FUNC_ADD, 32'sd99, 32'sd1);
        send_request(FUNC_SET, 32'sd99, 32'sd2);
        send_request(FUNC_SET, KEY_MAX, 32'sd0);
        send_request(FUNC_SET, t_word'((TABLE_DEPTH - 1) * 3), 32'sd1234);
        // The first of the two entries under key -1 holds -1 itself, which a
        // lookup must report as found.
        send_request(FUNC_GET, -32'sd1, 32'sd0);
        send_request(FUNC_DELETE, -32'sd1, 32'sd0);
        send_request(FUNC_GET, -32'sd1, 32'sd0);
        send_request(FUNC_DELETE, KEY_MIN, 32'sd0);
    endtask

    // Random phases of 20 to 80 beats. Each phase takes a fresh key pool and
    // an operation mix that grows, shrinks or churns the table, so the table
    // passes through empty and full many times. Some phases run with no
    // idling, and some end by draining every response before going on.
    task automatic run_random();
        int remaining;
        int phase_len;
        int mix;
        remaining = RANDOM_ITEMS;
        while (remaining > 0) begin
            phase_len = $urandom_range(20, 80);
            if (phase_len > remaining) phase_len = remaining;
            mix  = $urandom_range(MIX_GROW, MIX_CHURN);
            calm = ($urandom_range(0, 3) == 0);
            foreach (key_pool[i]) key_pool[i] = corner_or_random();
            for (int n = 0; n < phase_len; n++) begin
                send_request(pick_func(mix), pick_key(), corner_or_random());
            end
            remaining -= phase_len;
            if ($urandom_range(0, 3) == 0) wait_for_all_responses();
        end
    endtask

    // Response side: before each beat the receiver holds ready low for a
    // random number of cycles, then keeps it high until a beat is taken.
    initial begin
        int stall;
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        calm         = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.func  = FUNC_ADD;
        req_ch.key   = '0;
        req_ch.value = '0;
        items_sent   = 0;
        foreach (sent_by_op[i]) sent_by_op[i] = 0;
        foreach (key_pool[i]) key_pool[i] = '0;
        // Reset is held low from time zero and released at a falling edge.
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        // The sender stops here until the directed part is fully answered.
        wait_for_all_responses();
        run_random();

        req_ch.valid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && pending != 0; n++) @(negedge i_clk);
        // A settling wait catches any response beat the block should not send.
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Sent %0d requests: %0d add, %0d set, %0d delete, %0d get.",
                 items_sent, sent_by_op[FUNC_ADD], sent_by_op[FUNC_SET],
                 sent_by_op[FUNC_DELETE], sent_by_op[FUNC_GET]);
        $display("Checked %0d responses, %0d refused as full, %0d with key not found.",
                 checked, full_seen, miss_seen);
        if (errors == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d responses never arrived", errors, pending);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Several times the slowest correct run: every beat with the longest gap,
    // the longest stall and the slowest operation.
    initial begin
        #5_000_000;
        $display("Timed out with %0d requests sent and %0d responses outstanding",
                 items_sent, pending);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
